// ===== src/assert_macros.svh =====
// Assertion macros for the top-level RTL file of the sector color binner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge while out of reset.
`define SCNB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another one on the next edge.
`define SCNB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCNB_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCNB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/scnb_pkg.sv =====
// Types, constants and codes shared by the sector color binner.
package scnb_pkg;

    localparam int NUM_SECTORS = 5;
    localparam int NUM_COLORS  = 4;
    localparam int NUM_CELLS   = NUM_SECTORS * NUM_COLORS;
    localparam int CELL_AW     = 5;
    localparam int COLOR_AW    = 2;

    localparam int OP_W        = 2;
    localparam int ANGLE_W     = 16;
    localparam int CFG_ANG_W   = 15;
    localparam int DIST_W      = 12;
    localparam int COLOR_W     = 3;
    localparam int SECTOR_W    = 3;
    localparam int LIFE_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_BLOB    = 2'd0;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_RED = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_HALF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_ANGLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL_DIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LIFE  = 3'd5;

    localparam logic [CFG_ANG_W-1:0] RST_FRONT_HALF = 15'd2000;
    localparam logic [CFG_ANG_W-1:0] RST_MID_ANGLE  = 15'd6000;
    localparam logic [CFG_ANG_W-1:0] RST_FAR_ANGLE  = 15'd13000;
    localparam logic [DIST_W-1:0]    RST_MAX_DIST   = 12'd1600;
    localparam logic [DIST_W-1:0]    RST_KILL_DIST  = 12'd288;
    localparam logic [LIFE_W-1:0]    RST_INIT_LIFE  = 16'd1;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [ANGLE_W-1:0] blob_angle;
        logic [DIST_W-1:0]         blob_distance;
        logic [COLOR_W-1:0]        blob_color;
    } t_in_item;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector_index;
        logic [COLOR_AW-1:0] color_index;
        logic [DIST_W-1:0]   nearest_distance;
        logic [LIFE_W-1:0]   life_left;
        logic                last_cell;
    } t_out_item;

    typedef struct packed {
        logic [CFG_ANG_W-1:0] front_half_angle;
        logic [CFG_ANG_W-1:0] mid_angle;
        logic [CFG_ANG_W-1:0] far_angle;
        logic [DIST_W-1:0]    max_distance;
        logic [DIST_W-1:0]    kill_distance;
        logic [LIFE_W-1:0]    initial_life;
    } t_cfg;

    typedef struct packed {
        logic [CELL_AW-1:0] rd_addr;
        logic               wr_en;
        logic [CELL_AW-1:0] wr_addr;
        logic [DIST_W-1:0]  wr_data;
        logic               clear;
        logic [DIST_W-1:0]  clear_val;
    } t_tbl_req;

endpackage

// ===== src/sector_color_nearest_binner_core.sv =====
// Top level of the sector color binner: command sequencer and life counter.
//
//  channel   direction  handshake                 payload
//  command   in         start, busy               i_item    (t_in_item)
//  result    out        o_strobe, no back-press   o_result  (t_out_item)
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A blob's accept beat reads its cell from the table, and then the
// read-modify-write state (busy high) writes the smaller distance back.
// A flush holds busy while it walks the table one cell a cycle; its 20
// result beats pass through the table read register and the result register.
// A restart and operation code three leave busy low.
// Reset is synchronous and active low; it loads the register defaults, sets
// the life count to one and marks every cell empty at once (no clearing pass).
// Results are shown for exactly one cycle: the receiver cannot stall them.
`include "assert_macros.svh"

module sector_color_nearest_binner_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  scnb_pkg::t_in_item                i_item,
    output logic                              o_strobe,
    output scnb_pkg::t_out_item               o_result,
    input  logic                              i_cfg_we,
    input  logic [scnb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scnb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [scnb_pkg::CELL_AW-1:0] LAST_CELL =
        scnb_pkg::CELL_AW'(scnb_pkg::NUM_CELLS - 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RMW   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    scnb_pkg::t_cfg       w_cfg;
    scnb_pkg::t_tbl_req   w_req;
    scnb_pkg::t_out_item  r_out;
    scnb_pkg::t_out_item  n_out;

    t_state                              r_state;
    t_state                              n_state;
    logic [scnb_pkg::CELL_AW-1:0]        r_cnt;
    logic [scnb_pkg::CELL_AW-1:0]        n_cnt;
    logic [scnb_pkg::LIFE_W-1:0]         r_life;
    logic [scnb_pkg::LIFE_W-1:0]         n_life;
    logic                                r_strobe;
    logic                                n_strobe;
    logic [scnb_pkg::CELL_AW-1:0]        r_cell;
    logic [scnb_pkg::DIST_W-1:0]         r_dist;
    logic                                r_bin;

    logic                                w_accept;
    logic                                w_blob_ok;
    logic                                w_sec_hit;
    logic [scnb_pkg::SECTOR_W-1:0]       w_sector;
    logic                                w_bin;
    logic [scnb_pkg::CELL_AW-1:0]        w_cell;
    logic [scnb_pkg::DIST_W-1:0]         w_rd_data;
    logic                                w_last;
    logic                                w_flush_go;
    logic                                w_restart_go;
    logic                                w_last_beat;
    logic                                w_first_beat;

    scnb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    scnb_sector u_sector (
        .i_angle  (i_item.blob_angle),
        .i_front  (w_cfg.front_half_angle),
        .i_mid    (w_cfg.mid_angle),
        .i_far    (w_cfg.far_angle),
        .o_hit    (w_sec_hit),
        .o_sector (w_sector)
    );

    scnb_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_last   = (r_cnt == LAST_CELL);

    // A blob at or beyond the cutoff is dropped before any other check.
    assign w_blob_ok = w_accept && (i_item.operation == scnb_pkg::OP_BLOB)
                    && (i_item.blob_distance < w_cfg.max_distance);
    assign w_bin     = w_blob_ok && w_sec_hit
                    && (i_item.blob_color < scnb_pkg::COLOR_W'(scnb_pkg::NUM_COLORS));
    // Cell index is sector * 4 + color; park it at zero when the blob is not binned.
    assign w_cell    = w_bin ? {w_sector, i_item.blob_color[scnb_pkg::COLOR_AW-1:0]} : '0;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_life   = r_life;
        n_strobe = 1'b0;
        n_out    = r_out;

        w_req.rd_addr   = '0;
        w_req.wr_en     = 1'b0;
        w_req.wr_addr   = r_cell;
        w_req.wr_data   = r_dist;
        w_req.clear     = 1'b0;
        w_req.clear_val = w_cfg.max_distance;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_item.operation)
                        scnb_pkg::OP_BLOB: begin
                            w_req.rd_addr = w_cell;
                            // Close red hit costs one life, floor at zero.
                            if (w_blob_ok && i_item.blob_color == scnb_pkg::COLOR_RED
                                && i_item.blob_distance < w_cfg.kill_distance
                                && r_life != '0) begin
                                n_life = r_life - 1'b1;
                            end
                            n_state = S_RMW;
                        end
                        scnb_pkg::OP_FLUSH: begin
                            w_req.rd_addr = '0;
                            n_cnt         = '0;
                            n_state       = S_FLUSH;
                        end
                        scnb_pkg::OP_RESTART: begin
                            n_life      = w_cfg.initial_life;
                            w_req.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RMW: begin
                // Keep the nearer of the stored and the new distance.
                w_req.wr_en = r_bin && (r_dist < w_rd_data);
                n_state     = S_IDLE;
            end
            S_FLUSH: begin
                // Emit the cell read last cycle and fetch the next one; after the last cell, clear the table.
                n_strobe               = 1'b1;
                n_out.sector_index     = r_cnt[scnb_pkg::CELL_AW-1:scnb_pkg::COLOR_AW];
                n_out.color_index      = r_cnt[scnb_pkg::COLOR_AW-1:0];
                n_out.nearest_distance = w_rd_data;
                n_out.life_left        = r_life;
                n_out.last_cell        = w_last;
                if (w_last) begin
                    w_req.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    w_req.rd_addr = r_cnt + 1'b1;
                    n_cnt         = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_life   <= scnb_pkg::RST_INIT_LIFE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_life   <= n_life;
            r_strobe <= n_strobe;
        end
    end

    // Payload: hold the blob for its write-back cycle and the result beat.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_cell <= w_cell;
            r_dist <= i_item.blob_distance;
            r_bin  <= w_bin;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    assign w_flush_go   = w_accept && (i_item.operation == scnb_pkg::OP_FLUSH);
    assign w_restart_go = w_accept && (i_item.operation == scnb_pkg::OP_RESTART);
    assign w_last_beat  = o_strobe && o_result.last_cell;
    assign w_first_beat = o_strobe && (o_result.sector_index == '0)
                       && (o_result.color_index == '0);

    `SCNB_ASSERT_NEXT(a_rmw_one_cycle, i_clk, i_rst_n, r_state == S_RMW, !busy, "rmw stuck")
    `SCNB_ASSERT_NEXT(a_life_no_rise, i_clk, i_rst_n, !w_restart_go, r_life <= $past(r_life), "life up")
    `SCNB_ASSERT_NEXT(a_last_ends_flush, i_clk, i_rst_n, w_last_beat, !o_strobe, "beat after last")
    `SCNB_ASSERT(a_flush_emits, i_clk, i_rst_n, w_flush_go |-> ##2 w_first_beat, "first cell late")

endmodule

// ===== src/scnb_cfg_regs.sv =====
// Configuration register file of the sector color binner.
module scnb_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [scnb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scnb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output scnb_pkg::t_cfg                    o_cfg
);

    scnb_pkg::t_cfg r_cfg;

    // Write by index; drop writes past the register list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_half_angle <= scnb_pkg::RST_FRONT_HALF;
            r_cfg.mid_angle        <= scnb_pkg::RST_MID_ANGLE;
            r_cfg.far_angle        <= scnb_pkg::RST_FAR_ANGLE;
            r_cfg.max_distance     <= scnb_pkg::RST_MAX_DIST;
            r_cfg.kill_distance    <= scnb_pkg::RST_KILL_DIST;
            r_cfg.initial_life     <= scnb_pkg::RST_INIT_LIFE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scnb_pkg::CFG_FRONT_HALF: begin
                    r_cfg.front_half_angle <= i_cfg_data[scnb_pkg::CFG_ANG_W-1:0];
                end
                scnb_pkg::CFG_MID_ANGLE: begin
                    r_cfg.mid_angle <= i_cfg_data[scnb_pkg::CFG_ANG_W-1:0];
                end
                scnb_pkg::CFG_FAR_ANGLE: begin
                    r_cfg.far_angle <= i_cfg_data[scnb_pkg::CFG_ANG_W-1:0];
                end
                scnb_pkg::CFG_MAX_DIST: begin
                    r_cfg.max_distance <= i_cfg_data[scnb_pkg::DIST_W-1:0];
                end
                scnb_pkg::CFG_KILL_DIST: begin
                    r_cfg.kill_distance <= i_cfg_data[scnb_pkg::DIST_W-1:0];
                end
                scnb_pkg::CFG_INIT_LIFE: begin
                    r_cfg.initial_life <= i_cfg_data[scnb_pkg::LIFE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/scnb_sector.sv =====
// Angle to sector classifier of the sector color binner.
module scnb_sector (
    input  logic signed [scnb_pkg::ANGLE_W-1:0]   i_angle,
    input  logic [scnb_pkg::CFG_ANG_W-1:0]        i_front,
    input  logic [scnb_pkg::CFG_ANG_W-1:0]        i_mid,
    input  logic [scnb_pkg::CFG_ANG_W-1:0]        i_far,
    output logic                                  o_hit,
    output logic [scnb_pkg::SECTOR_W-1:0]         o_sector
);

    localparam int CW = scnb_pkg::ANGLE_W + 1;

    logic signed [CW-1:0] w_a;
    logic signed [CW-1:0] w_f;
    logic signed [CW-1:0] w_m;
    logic signed [CW-1:0] w_r;

    assign w_a = CW'(i_angle);
    assign w_f = $signed({2'b00, i_front});
    assign w_m = $signed({2'b00, i_mid});
    assign w_r = $signed({2'b00, i_far});

    // First matching band wins, so odd threshold orders just empty some bands.
    always_comb begin
        o_hit    = 1'b1;
        o_sector = 3'd0;
        priority if (w_a >= -w_f && w_a <= w_f) begin
            o_sector = 3'd0;
        end else if (w_a > w_f && w_a <= w_m) begin
            o_sector = 3'd1;
        end else if (w_a > w_m && w_a <= w_r) begin
            o_sector = 3'd2;
        end else if (w_a > -w_m && w_a <= -w_f) begin
            o_sector = 3'd3;
        end else if (w_a > -w_r && w_a <= -w_m) begin
            o_sector = 3'd4;
        end else begin
            o_hit = 1'b0;
        end
    end

endmodule

// ===== src/scnb_table.sv =====
// Nearest distance table: cell memory with valid bits and a clear value.
module scnb_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  scnb_pkg::t_tbl_req             i_req,
    output logic [scnb_pkg::DIST_W-1:0]    o_rd_data
);

    logic [scnb_pkg::DIST_W-1:0]    r_mem [scnb_pkg::NUM_CELLS];
    logic [scnb_pkg::DIST_W-1:0]    r_rd_data;
    logic [scnb_pkg::NUM_CELLS-1:0] r_valid;
    logic                           r_rd_vld;
    logic [scnb_pkg::DIST_W-1:0]    r_clear_val;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    // A cell not written since the last clear reads as the clear value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_clear_val <= scnb_pkg::RST_MAX_DIST;
        end else begin
            r_rd_vld <= r_valid[i_req.rd_addr];
            if (i_req.clear) begin
                r_valid     <= '0;
                r_clear_val <= i_req.clear_val;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_clear_val;

endmodule

// ===== verif/tb_sector_color_nearest_binner_core.sv =====
// Self-checking testbench for the sector color binner: table-driven edges, then random frames.
`timescale 1ns / 100ps

module tb_sector_color_nearest_binner_core;

    // Sector and color codes as the result beats number them.
    localparam int SEC_NONE      = -1;
    localparam int SEC_CENTER    = 0;
    localparam int SEC_LEFT_MID  = 1;
    localparam int SEC_LEFT_FAR  = 2;
    localparam int SEC_RIGHT_MID = 3;
    localparam int SEC_RIGHT_FAR = 4;

    localparam logic [scnb_pkg::COLOR_W-1:0] COLOR_CYAN      = 3'd0;
    localparam logic [scnb_pkg::COLOR_W-1:0] COLOR_YELLOW    = 3'd1;
    localparam logic [scnb_pkg::COLOR_W-1:0] COLOR_GREEN     = 3'd2;
    localparam logic [scnb_pkg::COLOR_W-1:0] COLOR_OTHER     = 3'd4;
    localparam logic [scnb_pkg::COLOR_W-1:0] COLOR_UNDEF_MAX = 3'd7;

    // Operation code with no meaning; the block must drop it.
    localparam logic [scnb_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    // Register indexes past the end of the list; writes there are dropped.
    localparam logic [scnb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [scnb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // A blob read-modify-write finishes as busy drops; give margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 30;
    localparam int SEG_COUNT     = 6;
    localparam int SEG_BEATS     = 64;

    typedef struct {
        scnb_pkg::t_in_item              item;
        bit                              typed;
        int                              cell_no;
        logic [scnb_pkg::DIST_W-1:0]     dist_val;
        logic [scnb_pkg::LIFE_W-1:0]     life;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    scnb_pkg::t_in_item              i_item;
    logic                            o_strobe;
    scnb_pkg::t_out_item             o_result;
    logic                            i_cfg_we;
    logic [scnb_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [scnb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    sector_color_nearest_binner_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block: register file, nearest-distance table, life count.
    scnb_pkg::t_cfg              cfg_model;
    logic [scnb_pkg::DIST_W-1:0] cell_dist [scnb_pkg::NUM_CELLS];
    logic [scnb_pkg::LIFE_W-1:0] life_count;

    // Result beats still owed by the block, oldest first.
    scnb_pkg::t_out_item cell_reports_q [$];

    int err_count;
    int beats_sent;
    int results_seen;
    int settings_used;
    int idle_pct;

    t_stim_row stim_table [25];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or never delivers its flush.
    initial begin
        #2_000_000;
        $display("sector_color_nearest_binner_core: mismatch");
        $finish;
    end

    function automatic void wipe_table();
        for (int k = 0; k < scnb_pkg::NUM_CELLS; k++) begin
            cell_dist[k] = cfg_model.max_distance;
        end
    endfunction

    // First match wins, in center, left mid, left far, right mid, right far order.
    function automatic int pick_sector(logic signed [scnb_pkg::ANGLE_W-1:0] angle);
        int a;
        int f;
        int m;
        int r;
        a = int'(angle);
        f = int'(cfg_model.front_half_angle);
        m = int'(cfg_model.mid_angle);
        r = int'(cfg_model.far_angle);
        if (a >= -f && a <= f) return SEC_CENTER;
        if (a > f && a <= m) return SEC_LEFT_MID;
        if (a > m && a <= r) return SEC_LEFT_FAR;
        if (a > -m && a <= -f) return SEC_RIGHT_MID;
        if (a > -r && a <= -m) return SEC_RIGHT_FAR;
        return SEC_NONE;
    endfunction

    // Advance the shadow by one accepted command beat; queue any flush reports.
    function automatic void bin_or_flush(scnb_pkg::t_in_item it);
        int                  sec;
        int                  cell_no;
        scnb_pkg::t_out_item rep;
        case (it.operation)
            scnb_pkg::OP_BLOB: begin
                if (it.blob_distance < cfg_model.max_distance) begin
                    // Life check runs even when the blob lands in no sector.
                    if (it.blob_color == scnb_pkg::COLOR_RED
                            && it.blob_distance < cfg_model.kill_distance
                            && life_count != '0) begin
                        life_count = life_count - 1'b1;
                    end
                    sec = pick_sector(it.blob_angle);
                    if (sec != SEC_NONE && it.blob_color < scnb_pkg::NUM_COLORS) begin
                        cell_no = sec * scnb_pkg::NUM_COLORS + int'(it.blob_color);
                        if (cell_dist[cell_no] > it.blob_distance) begin
                            cell_dist[cell_no] = it.blob_distance;
                        end
                    end
                end
            end
            scnb_pkg::OP_FLUSH: begin
                for (int k = 0; k < scnb_pkg::NUM_CELLS; k++) begin
                    rep.sector_index     = scnb_pkg::SECTOR_W'(k / scnb_pkg::NUM_COLORS);
                    rep.color_index      = scnb_pkg::COLOR_AW'(k % scnb_pkg::NUM_COLORS);
                    rep.nearest_distance = cell_dist[k];
                    rep.life_left        = life_count;
                    rep.last_cell        = (k == scnb_pkg::NUM_CELLS - 1);
                    cell_reports_q.push_back(rep);
                end
                wipe_table();
            end
            scnb_pkg::OP_RESTART: begin
                life_count = cfg_model.initial_life;
                wipe_table();
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    function automatic t_stim_row blob_row(int angle, int dist_val,
                                           logic [scnb_pkg::COLOR_W-1:0] color);
        t_stim_row row;
        row.item.operation     = scnb_pkg::OP_BLOB;
        row.item.blob_angle    = scnb_pkg::ANGLE_W'(angle);
        row.item.blob_distance = scnb_pkg::DIST_W'(dist_val);
        row.item.blob_color    = color;
        row.typed    = 1'b0;
        row.cell_no  = 0;
        row.dist_val = '0;
        row.life     = '0;
        return row;
    endfunction

    function automatic t_stim_row cmd_row(logic [scnb_pkg::OP_W-1:0] op);
        t_stim_row row;
        row = blob_row(0, 0, COLOR_CYAN);
        row.item.operation = op;
        return row;
    endfunction

    // Flush whose report for one cell is known without working it out.
    function automatic t_stim_row flush_row(int cell_no, int dist_val, int life);
        t_stim_row row;
        row = cmd_row(scnb_pkg::OP_FLUSH);
        row.typed    = 1'b1;
        row.cell_no  = cell_no;
        row.dist_val = scnb_pkg::DIST_W'(dist_val);
        row.life     = scnb_pkg::LIFE_W'(life);
        return row;
    endfunction

    // Mostly blobs with in-range distances, biased at the sector boundaries.
    function automatic scnb_pkg::t_in_item random_beat();
        scnb_pkg::t_in_item it;
        int                 pick;
        int                 a;
        int                 bound;
        pick = $urandom_range(0, 99);
        if (pick < 85)      it.operation = scnb_pkg::OP_BLOB;
        else if (pick < 92) it.operation = scnb_pkg::OP_FLUSH;
        else if (pick < 96) it.operation = scnb_pkg::OP_RESTART;
        else                it.operation = OP_SPARE;

        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: a = int'($urandom_range(0, 36000)) - 18000;
            5, 6, 7: begin
                case ($urandom_range(0, 3))
                    0:       bound = 0;
                    1:       bound = int'(cfg_model.front_half_angle);
                    2:       bound = int'(cfg_model.mid_angle);
                    default: bound = int'(cfg_model.far_angle);
                endcase
                a = bound + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1) == 1) a = -a;
            end
            default: a = int'($urandom);
        endcase
        it.blob_angle = scnb_pkg::ANGLE_W'(a);

        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            it.blob_distance =
                scnb_pkg::DIST_W'($urandom_range(0, cfg_model.max_distance - 1));
        end else if (pick < 8) begin
            it.blob_distance = scnb_pkg::DIST_W'($urandom_range(0, cfg_model.kill_distance));
        end else begin
            it.blob_distance = scnb_pkg::DIST_W'($urandom);
        end

        pick = $urandom_range(0, 9);
        if (pick < 8)       it.blob_color = scnb_pkg::COLOR_W'($urandom_range(0, 3));
        else if (pick == 8) it.blob_color = COLOR_OTHER;
        else                it.blob_color = scnb_pkg::COLOR_W'($urandom_range(5, 7));
        return it;
    endfunction

    // Hold start low until no report is owed and the block has gone quiet.
    task automatic drain();
        start <= 1'b0;
        while (cell_reports_q.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offer one command beat, maybe after an idle gap, and wait for acceptance.
    task automatic send(input scnb_pkg::t_in_item it);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            // Mostly short gaps; now and then long enough to span a whole flush.
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 30) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        bin_or_flush(it);
        beats_sent++;
    endtask

    // Write all six registers back to back, then the two unused indexes.
    task automatic program_regs(input scnb_pkg::t_cfg c);
        logic [scnb_pkg::CFG_IDX_W-1:0]  idx_list [8];
        logic [scnb_pkg::CFG_DATA_W-1:0] data_list [8];
        idx_list = '{scnb_pkg::CFG_FRONT_HALF, scnb_pkg::CFG_MID_ANGLE,
                     scnb_pkg::CFG_FAR_ANGLE, scnb_pkg::CFG_MAX_DIST,
                     scnb_pkg::CFG_KILL_DIST, scnb_pkg::CFG_INIT_LIFE,
                     CFG_SPARE_LO, CFG_SPARE_HI};
        // Fill unused upper data bits at random; the block must drop them.
        data_list[0] = {1'($urandom_range(0, 1)), c.front_half_angle};
        data_list[1] = {1'($urandom_range(0, 1)), c.mid_angle};
        data_list[2] = {1'($urandom_range(0, 1)), c.far_angle};
        data_list[3] = {4'($urandom), c.max_distance};
        data_list[4] = {4'($urandom), c.kill_distance};
        data_list[5] = c.initial_life;
        data_list[6] = scnb_pkg::CFG_DATA_W'($urandom);
        data_list[7] = scnb_pkg::CFG_DATA_W'($urandom);
        drain();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= data_list[k];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        cfg_model  = c;
        settings_used++;
    endtask

    // Compare each result beat with the oldest report owed.
    always @(posedge i_clk) begin
        scnb_pkg::t_out_item want;
        if (i_rst_n && o_strobe === 1'b1) begin
            results_seen++;
            if (cell_reports_q.size() == 0) begin
                $error("result beat with no report outstanding");
                err_count++;
            end else begin
                want = cell_reports_q.pop_front();
                check_field("sector_index", 32'(want.sector_index),
                            32'(o_result.sector_index));
                check_field("color_index", 32'(want.color_index),
                            32'(o_result.color_index));
                check_field("nearest_distance", 32'(want.nearest_distance),
                            32'(o_result.nearest_distance));
                check_field("life_left", 32'(want.life_left),
                            32'(o_result.life_left));
                check_field("last_cell", 32'(want.last_cell),
                            32'(o_result.last_cell));
            end
        end
    end

    initial begin
        scnb_pkg::t_cfg cfg_next;
        int             idx;

        err_count     = 0;
        beats_sent    = 0;
        results_seen  = 0;
        settings_used = 1;
        idle_pct      = 32;

        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;

        // Reset loads the register defaults, life of one and an empty table.
        cfg_model = '{front_half_angle: scnb_pkg::RST_FRONT_HALF,
                      mid_angle: scnb_pkg::RST_MID_ANGLE,
                      far_angle: scnb_pkg::RST_FAR_ANGLE,
                      max_distance: scnb_pkg::RST_MAX_DIST,
                      kill_distance: scnb_pkg::RST_KILL_DIST,
                      initial_life: scnb_pkg::RST_INIT_LIFE};
        life_count = scnb_pkg::RST_INIT_LIFE;
        wipe_table();

        // Edges of every sector under the default registers, the distance and
        // kill cutoffs, life saturating at zero, ignored colors and operations.
        stim_table = '{
            flush_row(SEC_CENTER * scnb_pkg::NUM_COLORS + int'(COLOR_CYAN), 1600, 1),
            blob_row(0, 0, COLOR_CYAN),
            blob_row(2000, 100, COLOR_YELLOW),
            blob_row(-2000, 50, COLOR_GREEN),
            blob_row(2001, 10, COLOR_CYAN),
            blob_row(6000, 20, COLOR_YELLOW),
            blob_row(6001, 30, COLOR_GREEN),
            blob_row(13000, 40, COLOR_CYAN),
            blob_row(13001, 5, COLOR_CYAN),
            blob_row(-2001, 60, COLOR_YELLOW),
            blob_row(-6000, 70, COLOR_GREEN),
            blob_row(-6001, 80, COLOR_CYAN),
            blob_row(-13000, 90, COLOR_YELLOW),
            blob_row(-12999, 288, scnb_pkg::COLOR_RED),
            blob_row(0, 1, COLOR_OTHER),
            blob_row(0, 1600, scnb_pkg::COLOR_RED),
            blob_row(0, 287, scnb_pkg::COLOR_RED),
            blob_row(500, 0, scnb_pkg::COLOR_RED),
            flush_row(SEC_CENTER * scnb_pkg::NUM_COLORS + int'(scnb_pkg::COLOR_RED), 0, 0),
            flush_row(SEC_CENTER * scnb_pkg::NUM_COLORS + int'(scnb_pkg::COLOR_RED), 1600, 0),
            cmd_row(OP_SPARE),
            cmd_row(scnb_pkg::OP_RESTART),
            blob_row(-32768, 4095, COLOR_UNDEF_MAX),
            blob_row(32767, 1, scnb_pkg::COLOR_RED),
            flush_row(SEC_CENTER * scnb_pkg::NUM_COLORS + int'(scnb_pkg::COLOR_RED), 1600, 0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table; a typed row replaces the worked-out report for its cell.
        foreach (stim_table[r]) begin
            send(stim_table[r].item);
            if (stim_table[r].typed) begin
                idx = cell_reports_q.size() - scnb_pkg::NUM_CELLS + stim_table[r].cell_no;
                cell_reports_q[idx].nearest_distance = stim_table[r].dist_val;
                cell_reports_q[idx].life_left        = stim_table[r].life;
            end
        end

        // Random frames: two register settings per idling pattern.
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            idle_pct = (seg < 2) ? 32 : (seg < 4) ? 48 : 0;
            case (seg)
                0: cfg_next = '{front_half_angle: 15'd0, mid_angle: 15'd18000,
                                far_angle: 15'd18000, max_distance: 12'd4095,
                                kill_distance: 12'd4095, initial_life: 16'd65535};
                1: cfg_next = '{front_half_angle: 15'd18000, mid_angle: 15'd0,
                                far_angle: 15'd0, max_distance: 12'd1,
                                kill_distance: 12'd0, initial_life: 16'd0};
                4: cfg_next = '{front_half_angle: scnb_pkg::RST_FRONT_HALF,
                                mid_angle: scnb_pkg::RST_MID_ANGLE,
                                far_angle: scnb_pkg::RST_FAR_ANGLE,
                                max_distance: scnb_pkg::RST_MAX_DIST,
                                kill_distance: scnb_pkg::RST_KILL_DIST,
                                initial_life: scnb_pkg::RST_INIT_LIFE};
                5: begin
                    // Unordered edges: sector regions may vanish.
                    cfg_next.front_half_angle = scnb_pkg::CFG_ANG_W'($urandom_range(0, 18000));
                    cfg_next.mid_angle        = scnb_pkg::CFG_ANG_W'($urandom_range(0, 18000));
                    cfg_next.far_angle        = scnb_pkg::CFG_ANG_W'($urandom_range(0, 18000));
                    cfg_next.max_distance     = scnb_pkg::DIST_W'($urandom_range(1, 4095));
                    cfg_next.kill_distance    = scnb_pkg::DIST_W'($urandom_range(0, 4095));
                    cfg_next.initial_life     = scnb_pkg::LIFE_W'($urandom_range(0, 65535));
                end
                default: begin
                    cfg_next.front_half_angle = scnb_pkg::CFG_ANG_W'($urandom_range(0, 6000));
                    cfg_next.mid_angle        = cfg_next.front_half_angle
                                                + scnb_pkg::CFG_ANG_W'($urandom_range(0, 6000));
                    cfg_next.far_angle        = cfg_next.mid_angle
                                                + scnb_pkg::CFG_ANG_W'($urandom_range(0, 6000));
                    cfg_next.max_distance     = scnb_pkg::DIST_W'($urandom_range(64, 4095));
                    cfg_next.kill_distance    = scnb_pkg::DIST_W'($urandom_range(0, 1024));
                    cfg_next.initial_life     = scnb_pkg::LIFE_W'($urandom_range(0, 8));
                end
            endcase
            program_regs(cfg_next);
            for (int n = 0; n < SEG_BEATS; n++) begin
                // Mid-segment, stop offering until every owed report is out.
                if (n == SEG_BEATS / 2) drain();
                send(random_beat());
            end
        end

        // Let the last flush finish and the tail settle.
        start <= 1'b0;
        while (cell_reports_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d command beats and %0d cell reports under %0d settings,",
                 beats_sent, results_seen, settings_used);
        $display("sector edges, cutoffs, life saturation and three idling patterns");
        if (err_count == 0) begin
            $display("sector_color_nearest_binner_core: match");
        end else begin
            $display("sector_color_nearest_binner_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/scnb_pkg.sv
src/scnb_cfg_regs.sv
src/scnb_sector.sv
src/scnb_table.sv
src/sector_color_nearest_binner_core.sv
verif/tb_sector_color_nearest_binner_core.sv
